// ----- design/nrmc_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA RMC field parser package
// Shared types, character codes, field numbers and the message id table.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam int NRMC_ACC_WIDTH = 32;
    localparam int NRMC_OUT_WIDTH = 32;
    localparam int NRMC_ID_LEN    = 6;

    // Character codes used by the parser.
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_W        = 8'h57;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    // Field numbers within a sentence.
    localparam logic [7:0] FLD_HEADER  = 8'd0;
    localparam logic [7:0] FLD_TIME    = 8'd1;
    localparam logic [7:0] FLD_STATUS  = 8'd2;
    localparam logic [7:0] FLD_LAT     = 8'd3;
    localparam logic [7:0] FLD_LAT_HEM = 8'd4;
    localparam logic [7:0] FLD_LON     = 8'd5;
    localparam logic [7:0] FLD_LON_HEM = 8'd6;
    localparam logic [7:0] FLD_SPEED   = 8'd7;
    localparam logic [7:0] FLD_COURSE  = 8'd8;

    localparam logic [7:0] CNT_MAX     = 8'hFF;

    typedef struct packed {
        logic [NRMC_OUT_WIDTH-1:0] fix_time;
        logic [NRMC_OUT_WIDTH-1:0] latitude;
        logic [NRMC_OUT_WIDTH-1:0] longitude;
        logic [NRMC_OUT_WIDTH-1:0] ground_speed;
        logic [NRMC_OUT_WIDTH-1:0] track_course;
        logic                      status_ok;
        logic                      header_bad;
        logic                      lat_not_north;
        logic                      lon_not_west;
    } nrmc_fix_t;

    // Expected message id "$GPRMC", one character per byte position.
    function automatic logic [7:0] id_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/nrmc_byte_if.sv -----
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one serial byte per transaction.
// ----------------------------------------------------------------------------
interface nrmc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- design/nrmc_fix_if.sv -----
// ----------------------------------------------------------------------------
// Fix result channel
// Valid/ready channel that carries one parsed RMC result per transaction.
// ----------------------------------------------------------------------------
interface nrmc_fix_if
    import nrmc_pkg::*;
;
    logic      valid;
    logic      ready;
    nrmc_fix_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/nmea_rmc_field_parser.sv -----
// ----------------------------------------------------------------------------
// NMEA RMC field parser
// Parses $GPRMC sentences byte by byte and reports one fix per line feed.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle and keeps doing so while
// a finished result waits on the output. A byte is registered on acceptance
// and applied to the sentence state when it leaves the input register; a
// line feed loads the output register at that same edge. The input only
// stalls when a line feed sits in the input register while the output
// register is still full and its result is not taken in that cycle.
module nmea_rmc_field_parser
    import nrmc_pkg::*;
#(
    parameter int ACC_WIDTH = NRMC_ACC_WIDTH
) (
    input  logic   clk,
    input  logic   rst_n,
    nrmc_byte_if.sink  rx,
    nrmc_fix_if.source fix
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    nrmc_fix_t  out_data_reg;
    nrmc_fix_t  core_fix;
    logic       in_is_lf;
    logic       step;

    assign in_is_lf = (in_byte_reg == CH_LF);
    assign step     = in_valid_reg && (!in_is_lf || !out_valid_reg || fix.ready);
    assign rx.ready = !in_valid_reg || step;
    assign fix.valid = out_valid_reg;
    assign fix.data  = out_data_reg;

    nrmc_field_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .fix     (core_fix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step && in_is_lf)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (fix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (step && in_is_lf)
        begin
            out_data_reg <= core_fix;
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> in_valid_reg && in_is_lf && out_valid_reg)
        else $error("input stalled without a blocked line feed");

    a_result_from_lf: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && in_is_lf))
        else $error("result raised without a line feed");

    a_lf_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_is_lf && out_valid_reg && !fix.ready |=> in_valid_reg && in_is_lf)
        else $error("blocked line feed lost from input register");

    a_no_step_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> in_valid_reg)
        else $error("state updated without a byte");
`endif

endmodule

// ----- design/nrmc_field_core.sv -----
// ----------------------------------------------------------------------------
// RMC field core
// Holds the sentence state and updates it for one byte per step.
// ----------------------------------------------------------------------------
module nrmc_field_core
    import nrmc_pkg::*;
#(
    parameter int ACC_WIDTH = NRMC_ACC_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic [7:0] rx_byte,
    output nrmc_fix_t fix
);

    logic [7:0]           field_index_reg, field_index_next;
    logic [7:0]           byte_position_reg, byte_position_next;
    logic [ACC_WIDTH-1:0] time_acc_reg, time_acc_next;
    logic [ACC_WIDTH-1:0] lat_acc_reg, lat_acc_next;
    logic [ACC_WIDTH-1:0] lon_acc_reg, lon_acc_next;
    logic [ACC_WIDTH-1:0] speed_acc_reg, speed_acc_next;
    logic [ACC_WIDTH-1:0] course_acc_reg, course_acc_next;
    logic [3:0]           error_marks_reg, error_marks_next;

    // Effective state once a '$' has cleared the sentence.
    logic                 restart;
    logic [7:0]           cur_field;
    logic [7:0]           cur_pos;
    logic [ACC_WIDTH-1:0] cur_time, cur_lat, cur_lon, cur_speed, cur_course;
    logic [3:0]           cur_marks;
    logic [ACC_WIDTH-1:0] digit_in;

    // acc * 10 + (byte - 48), folded into two shifts and adds.
    function automatic logic [ACC_WIDTH-1:0] push_digit(
        input logic [ACC_WIDTH-1:0] acc,
        input logic [ACC_WIDTH-1:0] dig
    );
        return (acc << 3) + (acc << 1) + dig;
    endfunction

    always_comb
    begin
        restart    = (rx_byte == CH_DOLLAR);
        cur_field  = restart ? '0 : field_index_reg;
        cur_pos    = restart ? '0 : byte_position_reg;
        cur_time   = restart ? '0 : time_acc_reg;
        cur_lat    = restart ? '0 : lat_acc_reg;
        cur_lon    = restart ? '0 : lon_acc_reg;
        cur_speed  = restart ? '0 : speed_acc_reg;
        cur_course = restart ? '0 : course_acc_reg;
        cur_marks  = restart ? '0 : error_marks_reg;
        digit_in   = ACC_WIDTH'(rx_byte) - ACC_WIDTH'(CH_ZERO);

        field_index_next   = cur_field;
        byte_position_next = (cur_pos == CNT_MAX) ? cur_pos : cur_pos + 8'd1;
        time_acc_next      = cur_time;
        lat_acc_next       = cur_lat;
        lon_acc_next       = cur_lon;
        speed_acc_next     = cur_speed;
        course_acc_next    = cur_course;
        error_marks_next   = cur_marks;

        if (rx_byte == CH_COMMA)
        begin
            if (cur_field != CNT_MAX)
            begin
                field_index_next = cur_field + 8'd1;
            end
        end
        else if (rx_byte != CH_LF && rx_byte != CH_DOT)
        begin
            case (cur_field)
                FLD_HEADER:
                begin
                    if (cur_pos >= 8'(NRMC_ID_LEN) || rx_byte != id_char(cur_pos[2:0]))
                    begin
                        error_marks_next[1] = 1'b1;
                    end
                end
                FLD_TIME:    time_acc_next   = push_digit(cur_time, digit_in);
                FLD_STATUS:
                begin
                    if (rx_byte != CH_A)
                    begin
                        error_marks_next[0] = 1'b1;
                    end
                end
                FLD_LAT:     lat_acc_next    = push_digit(cur_lat, digit_in);
                FLD_LAT_HEM:
                begin
                    if (rx_byte != CH_N)
                    begin
                        error_marks_next[2] = 1'b1;
                    end
                end
                FLD_LON:     lon_acc_next    = push_digit(cur_lon, digit_in);
                FLD_LON_HEM:
                begin
                    if (rx_byte != CH_W)
                    begin
                        error_marks_next[3] = 1'b1;
                    end
                end
                FLD_SPEED:   speed_acc_next  = push_digit(cur_speed, digit_in);
                FLD_COURSE:  course_acc_next = push_digit(cur_course, digit_in);
                default:
                begin
                end
            endcase
        end

        // A line feed never coincides with a restart, so the stored state is
        // exactly what the result reports.
        fix.fix_time      = NRMC_OUT_WIDTH'(time_acc_reg);
        fix.latitude      = NRMC_OUT_WIDTH'(lat_acc_reg);
        fix.longitude     = NRMC_OUT_WIDTH'(lon_acc_reg);
        fix.ground_speed  = NRMC_OUT_WIDTH'(speed_acc_reg);
        fix.track_course  = NRMC_OUT_WIDTH'(course_acc_reg);
        fix.status_ok     = ~error_marks_reg[0];
        fix.header_bad    = error_marks_reg[1];
        fix.lat_not_north = error_marks_reg[2];
        fix.lon_not_west  = error_marks_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg   <= '0;
            byte_position_reg <= '0;
            time_acc_reg      <= '0;
            lat_acc_reg       <= '0;
            lon_acc_reg       <= '0;
            speed_acc_reg     <= '0;
            course_acc_reg    <= '0;
            error_marks_reg   <= '0;
        end
        else if (step)
        begin
            field_index_reg   <= field_index_next;
            byte_position_reg <= byte_position_next;
            time_acc_reg      <= time_acc_next;
            lat_acc_reg       <= lat_acc_next;
            lon_acc_reg       <= lon_acc_next;
            speed_acc_reg     <= speed_acc_next;
            course_acc_reg    <= course_acc_next;
            error_marks_reg   <= error_marks_next;
        end
    end

endmodule
